### src/alist_pkg.sv
// Shared types, codes and constants of the array list block.
`default_nettype none
package alist_pkg;

    // Default storage geometry
    localparam int ALIST_DEPTH      = 32;
    localparam int ALIST_ELEM_WIDTH = 32;

    // Fixed field widths of the two channels
    localparam int OP_W   = 3;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;
    localparam int IDX_W  = 5;
    localparam int LEN_W  = 6;

    // Operation codes; codes above OP_TRAVERSE are ignored
    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_DELETE   = 3'd2,
        OP_SEARCH   = 3'd3,
        OP_TRAVERSE = 3'd4
    } t_alist_op;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 3'd0,
        ST_BADPOS = 3'd1,
        ST_FULL   = 3'd2,
        ST_MATCH  = 3'd3,
        ST_ELEM   = 3'd4,
        ST_NONE   = 3'd5
    } t_alist_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_PRIME,
        S_SHIFT,
        S_COUNT,
        S_LIST,
        S_RESULT
    } t_alist_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic          load;        // capture the accepted transaction
        logic          start_scan;  // set walk start address and length
        logic          adv;         // step the walk to the next entry
        logic          count_hit;   // bump the match count
        logic          hits_dec;    // one match fewer still to send
        logic          shift_wr;    // move the entry read to its new slot
        logic          put_val;     // write the new value into the list
        logic          cnt_inc;     // list grows by one
        logic          cnt_dec;     // list shrinks by one
        logic          emit;        // load the output register
        t_alist_status status;      // status of the emitted result
    } t_alist_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_alist_op op;
        logic      full;
        logic      ins_bad;
        logic      del_bad;
        logic      empty;
        logic      left_zero;
        logic      match;
        logic      hits_zero;
        logic      out_free;
    } t_alist_flags;

endpackage
`default_nettype wire

### src/alist_ram.sv
// Generic single write port RAM with one registered read port.
`default_nettype none
module alist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### src/alist_ctrl.sv
// Controller state machine of the array list block.
`default_nettype none
module alist_ctrl (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire alist_pkg::t_alist_flags i_flags,
    output alist_pkg::t_alist_cmd        o_cmd
);
    import alist_pkg::*;

    t_alist_state  r_state,  n_state;
    t_alist_status r_status, n_status;
    logic          r_pass,   n_pass;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_NONE;
            r_pass   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_pass   <= n_pass;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_pass       = r_pass;
        o_cmd        = '0;
        o_cmd.status = r_status;
        o_in_ready   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_pass     = 1'b0;
                    n_state    = S_DECIDE;
                end
            end

            // Check the transaction and either answer at once or start a walk
            S_DECIDE: begin
                unique case (i_flags.op)
                    OP_APPEND: begin
                        n_state = S_RESULT;
                        if (i_flags.full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_cmd.put_val = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                            n_status      = ST_DONE;
                        end
                    end
                    OP_INSERT: begin
                        if (i_flags.ins_bad) begin
                            n_status = ST_BADPOS;
                            n_state  = S_RESULT;
                        end else if (i_flags.full) begin
                            n_status = ST_FULL;
                            n_state  = S_RESULT;
                        end else begin
                            o_cmd.start_scan = 1'b1;
                            n_state          = S_PRIME;
                        end
                    end
                    OP_DELETE: begin
                        if (i_flags.del_bad) begin
                            n_status = ST_BADPOS;
                            n_state  = S_RESULT;
                        end else begin
                            o_cmd.start_scan = 1'b1;
                            n_state          = S_PRIME;
                        end
                    end
                    OP_SEARCH, OP_TRAVERSE: begin
                        if (i_flags.empty) begin
                            n_status = ST_NONE;
                            n_state  = S_RESULT;
                        end else begin
                            o_cmd.start_scan = 1'b1;
                            n_state          = S_PRIME;
                        end
                    end
                    default: begin
                        n_status = ST_NONE;
                        n_state  = S_RESULT;
                    end
                endcase
            end

            // Wait for the first read of the walk
            S_PRIME: begin
                priority if (i_flags.op == OP_INSERT || i_flags.op == OP_DELETE) begin
                    n_state = S_SHIFT;
                end else if (i_flags.op == OP_SEARCH && !r_pass) begin
                    n_state = S_COUNT;
                end else begin
                    n_state = S_LIST;
                end
            end

            // Move one entry a cycle, then finish the update
            S_SHIFT: begin
                if (i_flags.left_zero) begin
                    if (i_flags.op == OP_INSERT) begin
                        o_cmd.put_val = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end else begin
                        o_cmd.cnt_dec = 1'b1;
                    end
                    n_status = ST_DONE;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.shift_wr = 1'b1;
                    o_cmd.adv      = 1'b1;
                end
            end

            // First search pass: count matches
            S_COUNT: begin
                if (i_flags.left_zero) begin
                    if (i_flags.hits_zero) begin
                        n_status = ST_NONE;
                        n_state  = S_RESULT;
                    end else begin
                        o_cmd.start_scan = 1'b1;
                        n_pass           = 1'b1;
                        n_state          = S_PRIME;
                    end
                end else begin
                    o_cmd.adv       = 1'b1;
                    o_cmd.count_hit = i_flags.match;
                end
            end

            // Send matches or every entry, holding while the output is full
            S_LIST: begin
                if (i_flags.left_zero) begin
                    n_state = S_IDLE;
                end else if (i_flags.op == OP_SEARCH) begin
                    if (!i_flags.match) begin
                        o_cmd.adv = 1'b1;
                    end else if (i_flags.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.status   = ST_MATCH;
                        o_cmd.hits_dec = 1'b1;
                        o_cmd.adv      = 1'b1;
                    end
                end else if (i_flags.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_ELEM;
                    o_cmd.adv    = 1'b1;
                end
            end

            // Send the single result of the transaction
            S_RESULT: begin
                if (i_flags.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### src/alist_dp.sv
// Datapath of the array list block: entry store, walk counters and output register.
`default_nettype none
module alist_dp #(
    parameter int DEPTH      = alist_pkg::ALIST_DEPTH,
    parameter int ELEM_WIDTH = alist_pkg::ALIST_ELEM_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire alist_pkg::t_alist_cmd          i_cmd,
    output alist_pkg::t_alist_flags             o_flags,
    input  wire logic [alist_pkg::OP_W-1:0]     i_operation,
    input  wire logic [alist_pkg::POS_W-1:0]    i_position,
    input  wire logic signed [alist_pkg::VAL_W-1:0] i_value,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [alist_pkg::STAT_W-1:0]        o_status,
    output logic [alist_pkg::IDX_W-1:0]         o_index,
    output logic signed [alist_pkg::VAL_W-1:0]  o_element,
    output logic [alist_pkg::LEN_W-1:0]         o_length,
    output logic                                o_last
);
    import alist_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [OP_W-1:0]       r_op;
    logic [POS_W-1:0]      r_pos;
    logic [ELEM_WIDTH-1:0] r_val;
    logic [ELEM_WIDTH-1:0] r_gone;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_left;
    logic [CW-1:0]         r_hits;
    logic [AW-1:0]         r_src;
    logic                  r_first;

    t_alist_op             op;
    logic                  down;
    logic                  is_del;
    logic [AW-1:0]         src_next;
    logic [AW-1:0]         dst;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         waddr;
    logic [ELEM_WIDTH-1:0] wdata;
    logic                  we;
    logic [ELEM_WIDTH-1:0] rd_data;
    logic                  capture_gone;
    logic                  out_free;

    assign op     = t_alist_op'(r_op);
    assign down   = (op == OP_INSERT);
    assign is_del = (op == OP_DELETE);

    // Walk addressing: insert walks down, the rest walk up
    assign src_next = down ? AW'(r_src - 1'b1) : AW'(r_src + 1'b1);
    assign dst      = down ? AW'(r_src + 1'b1) : AW'(r_src - 1'b1);
    assign raddr    = i_cmd.adv ? src_next : r_src;

    // The first entry read by a delete is the removed one, not a move
    assign capture_gone = i_cmd.shift_wr && is_del && r_first;

    // Write port: entry moves during a walk, new value otherwise
    always_comb begin
        we    = (i_cmd.shift_wr && !capture_gone) || i_cmd.put_val;
        waddr = dst;
        wdata = rd_data;
        if (i_cmd.put_val) begin
            waddr = (op == OP_APPEND) ? AW'(r_count) : AW'(r_pos);
            wdata = r_val;
        end
    end

    alist_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign out_free = !o_out_valid || i_out_ready;

    // Status towards the controller
    always_comb begin
        o_flags           = '0;
        o_flags.op        = op;
        o_flags.full      = (r_count >= CW'(DEPTH));
        o_flags.ins_bad   = (CMPW'(r_pos) > CMPW'(r_count));
        o_flags.del_bad   = (r_pos == '0) || (CMPW'(r_pos) > CMPW'(r_count));
        o_flags.empty     = (r_count == '0);
        o_flags.left_zero = (r_left == '0);
        o_flags.match     = (rd_data == r_val);
        o_flags.hits_zero = (r_hits == '0);
        o_flags.out_free  = out_free;
    end

    // Capture the transaction and run the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_pos <= i_position;
            r_val <= ELEM_WIDTH'(i_value);
        end
        if (i_cmd.start_scan) begin
            r_first <= 1'b1;
            unique case (op)
                OP_INSERT: begin
                    r_src  <= AW'(r_count - 1'b1);
                    r_left <= r_count - CW'(r_pos);
                end
                OP_DELETE: begin
                    r_src  <= AW'(r_pos - 1'b1);
                    r_left <= CW'(r_count - CW'(r_pos) + 1'b1);
                end
                default: begin
                    r_src  <= '0;
                    r_left <= r_count;
                end
            endcase
        end else if (i_cmd.adv) begin
            r_first <= 1'b0;
            r_src   <= src_next;
            r_left  <= r_left - 1'b1;
        end
        if (capture_gone) begin
            r_gone <= rd_data;
        end
    end

    // Match count for the search passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= '0;
        end else if (i_cmd.load) begin
            r_hits <= '0;
        end else if (i_cmd.count_hit) begin
            r_hits <= r_hits + 1'b1;
        end else if (i_cmd.hits_dec) begin
            r_hits <= r_hits - 1'b1;
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Output valid: set on emit, drop once the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status <= i_cmd.status;
            o_length <= LEN_W'(r_count);
            unique case (i_cmd.status)
                ST_DONE: begin
                    o_last <= 1'b1;
                    unique case (op)
                        OP_APPEND: begin
                            o_index   <= IDX_W'(r_count - 1'b1);
                            o_element <= VAL_W'(signed'(r_val));
                        end
                        OP_INSERT: begin
                            o_index   <= IDX_W'(r_pos);
                            o_element <= VAL_W'(signed'(r_val));
                        end
                        default: begin
                            o_index   <= IDX_W'(r_pos - 1'b1);
                            o_element <= VAL_W'(signed'(r_gone));
                        end
                    endcase
                end
                ST_MATCH: begin
                    o_index   <= IDX_W'(r_src);
                    o_element <= VAL_W'(signed'(rd_data));
                    o_last    <= (r_hits == CW'(1));
                end
                ST_ELEM: begin
                    o_index   <= IDX_W'(r_src);
                    o_element <= VAL_W'(signed'(rd_data));
                    o_last    <= (r_left == CW'(1));
                end
                default: begin
                    o_index   <= '0;
                    o_element <= '0;
                    o_last    <= 1'b1;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### src/array_list_insert_delete_search_top.sv
// Top level of the array list block: controller joined to the datapath.
//
// Keeps an ordered list of up to DEPTH signed words in a single RAM with a
// registered read port, plus an entry count. Transactions are taken one at a
// time; the input is ready only while the block is idle, and a finished
// result may still wait in the output register when the next transaction is
// taken. Insert and delete move one entry a cycle through the RAM port, and
// search walks the list twice: one pass counts the matches so the final one
// can be flagged, a second sends them. Every result waits while the output
// side stalls. The entry store has no clearing pass: entries beyond the count
// are never used.
`default_nettype none
module array_list_insert_delete_search_top #(
    parameter int DEPTH      = alist_pkg::ALIST_DEPTH,
    parameter int ELEM_WIDTH = alist_pkg::ALIST_ELEM_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [alist_pkg::OP_W-1:0]         i_operation,
    input  wire logic [alist_pkg::POS_W-1:0]        i_position,
    input  wire logic signed [alist_pkg::VAL_W-1:0] i_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [alist_pkg::STAT_W-1:0]            o_status,
    output logic [alist_pkg::IDX_W-1:0]             o_index,
    output logic signed [alist_pkg::VAL_W-1:0]      o_element,
    output logic [alist_pkg::LEN_W-1:0]             o_length,
    output logic                                    o_last
);
    import alist_pkg::*;

    t_alist_cmd   cmd;
    t_alist_flags flags;

    alist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_flags    (flags),
        .o_cmd      (cmd)
    );

    alist_dp #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_flags     (flags),
        .i_operation (i_operation),
        .i_position  (i_position),
        .i_value     (i_value),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_index     (o_index),
        .o_element   (o_element),
        .o_length    (o_length),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench of the array list block: directed table, then random traffic.
`default_nettype none
module tb;
    import alist_pkg::*;

    localparam int DEPTH          = ALIST_DEPTH;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int STALL_CYCLES   = 300;
    localparam int TAIL_CYCLES    = 80;
    localparam int N_DIRECTED     = 25;

    // Codes the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

    typedef struct packed {
        t_alist_status          status;
        logic [IDX_W-1:0]       index;
        logic signed [VAL_W-1:0] element;
        logic [LEN_W-1:0]       length;
        logic                   last;
    } t_list_result;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [POS_W-1:0]       pos;
        logic signed [VAL_W-1:0] val;
        logic                   typed;
        t_list_result           want;
    } t_stim_row;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic [OP_W-1:0]         i_operation = '0;
    logic [POS_W-1:0]        i_position  = '0;
    logic signed [VAL_W-1:0] i_value     = '0;
    logic                    i_out_ready = 1'b0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic [STAT_W-1:0]       o_status;
    logic [IDX_W-1:0]        o_index;
    logic signed [VAL_W-1:0] o_element;
    logic [LEN_W-1:0]        o_length;
    logic                    o_last;

    // Mirror of the list and the results still owed by the block
    logic signed [VAL_W-1:0] list_mem [DEPTH];
    int                      list_len = 0;
    t_list_result            pending_results [$];

    // Transaction on offer and its typed expectation, if any
    logic                    cur_typed = 1'b0;
    t_list_result            cur_want  = '0;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit stall_req    = 1'b0;
    int err_count    = 0;
    int quiet_cycles = 0;

    // Directed table; typed expectations only where they are obvious
    t_stim_row dir_rows [N_DIRECTED] = '{
        '{OP_TRAVERSE, 6'd0, 32'sd0, 1'b1, '{ST_NONE, 5'd0, 32'sd0, 6'd0, 1'b1}},
        '{OP_SEARCH, 6'd0, 32'sd0, 1'b1, '{ST_NONE, 5'd0, 32'sd0, 6'd0, 1'b1}},
        '{OP_DELETE, 6'd0, 32'sd0, 1'b1, '{ST_BADPOS, 5'd0, 32'sd0, 6'd0, 1'b1}},
        '{OP_DELETE, 6'd1, 32'sd0, 1'b1, '{ST_BADPOS, 5'd0, 32'sd0, 6'd0, 1'b1}},
        '{OP_INSERT, 6'd1, 32'sd9, 1'b1, '{ST_BADPOS, 5'd0, 32'sd0, 6'd0, 1'b1}},
        '{OP_INSERT, 6'd0, 32'sd5, 1'b1, '{ST_DONE, 5'd0, 32'sd5, 6'd1, 1'b1}},
        '{OP_APPEND, 6'd0, 32'h7fff_ffff, 1'b1,
            '{ST_DONE, 5'd1, 32'h7fff_ffff, 6'd2, 1'b1}},
        '{OP_APPEND, 6'd63, 32'h8000_0000, 1'b1,
            '{ST_DONE, 5'd2, 32'h8000_0000, 6'd3, 1'b1}},
        '{OP_APPEND, 6'd0, 32'hffff_ffff, 1'b1,
            '{ST_DONE, 5'd3, 32'hffff_ffff, 6'd4, 1'b1}},
        '{OP_INSERT, 6'd4, 32'sd5, 1'b1, '{ST_DONE, 5'd4, 32'sd5, 6'd5, 1'b1}},
        '{OP_INSERT, 6'd2, 32'sd5, 1'b0, '0},
        '{OP_SEARCH, 6'd0, 32'sd5, 1'b0, '0},
        '{OP_SEARCH, 6'd0, 32'sd12345, 1'b1, '{ST_NONE, 5'd0, 32'sd0, 6'd6, 1'b1}},
        '{OP_TRAVERSE, 6'd63, 32'sd0, 1'b0, '0},
        '{OP_INSERT, 6'd63, 32'sd1, 1'b1, '{ST_BADPOS, 5'd0, 32'sd0, 6'd6, 1'b1}},
        '{OP_INSERT, 6'd32, 32'sd1, 1'b1, '{ST_BADPOS, 5'd0, 32'sd0, 6'd6, 1'b1}},
        '{OP_DELETE, 6'd7, 32'sd0, 1'b1, '{ST_BADPOS, 5'd0, 32'sd0, 6'd6, 1'b1}},
        '{OP_DELETE, 6'd6, 32'sd0, 1'b0, '0},
        '{OP_DELETE, 6'd1, 32'sd0, 1'b0, '0},
        '{OP_DELETE, 6'd0, 32'sd0, 1'b1, '{ST_BADPOS, 5'd0, 32'sd0, 6'd4, 1'b1}},
        '{OP_UNUSED_LO, 6'd1, 32'sd5, 1'b1, '{ST_NONE, 5'd0, 32'sd0, 6'd4, 1'b1}},
        '{OP_UNUSED_MID, 6'd2, 32'sd5, 1'b1, '{ST_NONE, 5'd0, 32'sd0, 6'd4, 1'b1}},
        '{OP_UNUSED_HI, 6'd63, 32'hffff_ffff, 1'b1,
            '{ST_NONE, 5'd0, 32'sd0, 6'd4, 1'b1}},
        '{OP_SEARCH, 6'd0, 32'h8000_0000, 1'b0, '0},
        '{OP_TRAVERSE, 6'd0, 32'sd0, 1'b0, '0}
    };

    array_list_insert_delete_search_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_index     (o_index),
        .o_element   (o_element),
        .o_length    (o_length),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Queue one result with the current list length
    function automatic void push_result(input t_alist_status st, input int idx,
                                        input logic signed [VAL_W-1:0] el, input bit lst);
        t_list_result r;
        r.status  = st;
        r.index   = IDX_W'(idx);
        r.element = el;
        r.length  = LEN_W'(list_len);
        r.last    = lst;
        pending_results.push_back(r);
    endfunction

    // Apply one transaction to the mirror list and queue what it yields
    function automatic void predict_list_op(input logic [OP_W-1:0] op,
                                            input logic [POS_W-1:0] pos,
                                            input logic signed [VAL_W-1:0] val);
        int n;
        int p;
        int hits;
        int seen;
        logic signed [VAL_W-1:0] gone;
        n    = list_len;
        p    = int'(pos);
        hits = 0;
        seen = 0;
        case (op)
            OP_APPEND: begin
                if (n >= DEPTH) begin
                    push_result(ST_FULL, 0, '0, 1'b1);
                end else begin
                    list_mem[n] = val;
                    list_len    = n + 1;
                    push_result(ST_DONE, n, val, 1'b1);
                end
            end
            OP_INSERT: begin
                if (p > n) begin
                    push_result(ST_BADPOS, 0, '0, 1'b1);
                end else if (n >= DEPTH) begin
                    push_result(ST_FULL, 0, '0, 1'b1);
                end else begin
                    for (int i = n; i > p; i--) list_mem[i] = list_mem[i-1];
                    list_mem[p] = val;
                    list_len    = n + 1;
                    push_result(ST_DONE, p, val, 1'b1);
                end
            end
            OP_DELETE: begin
                if (p == 0 || p > n) begin
                    push_result(ST_BADPOS, 0, '0, 1'b1);
                end else begin
                    gone = list_mem[p-1];
                    for (int i = p - 1; i + 1 < n; i++) list_mem[i] = list_mem[i+1];
                    list_len = n - 1;
                    push_result(ST_DONE, p - 1, gone, 1'b1);
                end
            end
            OP_SEARCH: begin
                for (int i = 0; i < n; i++) if (list_mem[i] == val) hits++;
                if (hits == 0) begin
                    push_result(ST_NONE, 0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        if (list_mem[i] == val) begin
                            seen++;
                            push_result(ST_MATCH, i, list_mem[i], seen == hits);
                        end
                    end
                end
            end
            OP_TRAVERSE: begin
                if (n == 0) begin
                    push_result(ST_NONE, 0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        push_result(ST_ELEM, i, list_mem[i], i + 1 == n);
                end
            end
            default: push_result(ST_NONE, 0, '0, 1'b1);
        endcase
    endfunction

    // Predict on input transactions, check output transactions, watch for a hang
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        bit           moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                predict_list_op(i_operation, i_position, i_value);
                if (cur_typed) pending_results[pending_results.size()-1] = cur_want;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                got = '{t_alist_status'(o_status), o_index, o_element, o_length, o_last};
                if (pending_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected: status %0d index %0d element %0d length %0d last %0d",
                             $time, got.status, got.index, got.element, got.length, got.last);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        err_count++;
                        $display("%0t: expected status %0d index %0d element %0d length %0d last %0d",
                                 $time, want.status, want.index, want.element, want.length,
                                 want.last);
                        $display("%0t: actual   status %0d index %0d element %0d length %0d last %0d",
                                 $time, got.status, got.index, got.element, got.length,
                                 got.last);
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, pending_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Output side: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                i_out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
                stall_req = 1'b0;
            end
            i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Offer one transaction and hold it until accepted; entered and left at a falling edge
    task automatic send_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val, input logic typed,
                                input t_list_result want);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        cur_typed = typed;
        cur_want  = want;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= val;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    initial begin
        int          k;
        int          pos;
        logic [2:0]  op;
        logic [31:0] val;
        bit          grow;
        grow = 1'b1;

        // Hold reset, then release on a falling edge
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        snd_idle_pct = 11;
        rcv_idle_pct = 76;
        foreach (dir_rows[r])
            send_list_op(dir_rows[r].op, dir_rows[r].pos, dir_rows[r].val,
                         dir_rows[r].typed, dir_rows[r].want);

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 1) ? 76 : (ph == 0) ? 11 : 0;
            rcv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 11 : 0;
            if (ph == 1) stall_req = 1'b1;
            repeat ((ph == 0) ? 85 : 110) begin
                // Steer the list between empty and full so both ends are visited
                if (grow && list_len == DEPTH && $urandom_range(3) == 0) grow = 1'b0;
                if (!grow && list_len == 0 && $urandom_range(3) == 0) grow = 1'b1;
                k = $urandom_range(99);
                if (grow)
                    op = (k < 40) ? OP_APPEND : (k < 65) ? OP_INSERT : (k < 75) ? OP_DELETE :
                         (k < 87) ? OP_SEARCH : (k < 95) ? OP_TRAVERSE :
                         3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                else
                    op = (k < 8) ? OP_APPEND : (k < 16) ? OP_INSERT : (k < 66) ? OP_DELETE :
                         (k < 80) ? OP_SEARCH : (k < 92) ? OP_TRAVERSE :
                         3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));

                // Mostly legal positions, some past the end and some anywhere
                k = $urandom_range(9);
                if (op == OP_INSERT)
                    pos = (k < 8) ? $urandom_range(0, list_len) :
                          (k == 8) ? $urandom_range(0, 63) : $urandom_range(list_len + 1, 63);
                else if (op == OP_DELETE && k < 8 && list_len > 0)
                    pos = $urandom_range(1, list_len);
                else
                    pos = $urandom_range(0, 63);

                // Small values repeat often, so searches find several matches
                k = $urandom_range(99);
                if (k < 45)
                    val = $urandom_range(0, 4) - 2;
                else if (k < 65 && list_len > 0)
                    val = list_mem[$urandom_range(0, list_len - 1)];
                else
                    val = $urandom;

                send_list_op(op, 6'(pos), val, 1'b0, '0);
            end
            // Pause until the block has delivered everything owed
            i_in_valid <= 1'b0;
            while (pending_results.size() != 0) @(negedge i_clk);
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire
